// File: rtl/lanc_pkg.sv
// Shared types, constants and helper functions for the LANC frame transceiver.
package lanc_pkg;

    // Width of the tick timer; it saturates at its maximum value.
    localparam int TIMER_BITS = 16;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    // Width used for deadline compares; covers both the timer and the sync setting.
    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_BIT_TICKS   = 2'd0;
    localparam logic [1:0] REG_START_TICKS = 2'd1;
    localparam logic [1:0] REG_SYNC_TICKS  = 2'd2;

    // Configuration reset values.
    localparam logic [9:0]  BIT_TICKS_RST   = 10'd104;
    localparam logic [9:0]  START_TICKS_RST = 10'd104;
    localparam logic [15:0] SYNC_TICKS_RST  = 16'd3000;

    // Index of the last of the eight byte slots: four sent, then four received.
    localparam logic [2:0] LAST_SLOT = 3'd7;

    typedef enum logic [2:0] {
        PH_SYNC = 3'd0,
        PH_WAIT = 3'd1,
        PH_SLOT = 3'd2,
        PH_HALF = 3'd3
    } t_phase;

    typedef enum logic [1:0] {
        DRV_IDLE = 2'd0,
        DRV_ONE  = 2'd1,
        DRV_ZERO = 2'd2
    } t_drive;

    // One result item as held in the output stage.
    typedef struct packed {
        logic [1:0]  line_drive;
        logic [31:0] rx_frame;
        logic        frame_done;
    } t_result;

    // Saturating increment of the tick timer.
    function automatic logic [TIMER_BITS-1:0] tick_inc(input logic [TIMER_BITS-1:0] t);
        return (t == TMAX) ? TMAX : t + TIMER_BITS'(1);
    endfunction

    // A deadline is met once the count reaches it or the timer has saturated.
    function automatic logic reached(input logic [TIMER_BITS-1:0] t,
                                     input logic [CMP_W-1:0] target);
        return (CMP_W'(t) >= target) || (t == TMAX);
    endfunction

endpackage

// File: rtl/lanc_frame_transceiver.sv
// LANC frame master: sync detection, four bytes driven and four sampled per frame.
// Results are registered, into the skid entry while the output is stalled.
// Throughput: one tick per cycle while the skid entry is empty; the output stage
// (register plus skid) keeps the input flowing while a result waits to be taken.
// Reset (i_rst_n low, synchronous): sync wait, counters and frames cleared,
// line released, received bytes zero, configuration back to 104/104/3000.
module lanc_frame_transceiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_line_level,
    input  logic [7:0]  i_tx_byte0,
    input  logic [7:0]  i_tx_byte1,
    input  logic [7:0]  i_tx_byte2,
    input  logic [7:0]  i_tx_byte3,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_line_drive,
    output logic [7:0]  o_rx_byte0,
    output logic [7:0]  o_rx_byte1,
    output logic [7:0]  o_rx_byte2,
    output logic [7:0]  o_rx_byte3,
    output logic        o_frame_done,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lanc_pkg::*;

    // Configuration registers
    logic [9:0]  r_bit_ticks;
    logic [9:0]  r_start_ticks;
    logic [15:0] r_sync_ticks;

    // Protocol state
    t_phase                r_phase,   n_phase;
    logic [2:0]            r_slot,    n_slot;
    logic [3:0]            r_bit,     n_bit;
    logic [TIMER_BITS-1:0] r_tick,    n_tick;
    logic [31:0]           r_tx,      n_tx;
    logic [31:0]           r_rx,      n_rx;
    t_drive                r_drive,   n_drive;
    logic [31:0]           r_rx_last, n_rx_last;
    logic                  n_done;

    // Output stage
    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic       in_xfer;
    logic       do_slot;
    logic       is_rx;
    logic [8:0] half_bit;
    logic [CMP_W-1:0] target;
    logic [4:0] bit_pos;
    logic [1:0] cfg_index;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign o_in_ready = !r_skid_valid;
    assign half_bit  = r_bit_ticks[9:1];
    assign is_rx     = r_slot[2];
    assign cfg_index = paddr[3:2];

    // Configuration writes and reads.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks   <= BIT_TICKS_RST;
            r_start_ticks <= START_TICKS_RST;
            r_sync_ticks  <= SYNC_TICKS_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_index)
                REG_BIT_TICKS:   r_bit_ticks   <= pwdata[9:0];
                REG_START_TICKS: r_start_ticks <= pwdata[9:0];
                REG_SYNC_TICKS:  r_sync_ticks  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_BIT_TICKS:   prdata = {22'd0, r_bit_ticks};
            REG_START_TICKS: prdata = {22'd0, r_start_ticks};
            REG_SYNC_TICKS:  prdata = {16'd0, r_sync_ticks};
            default:         prdata = 32'd0;
        endcase
    end

    // Next state for one tick: phase handling, then the shared slot work.
    always_comb begin
        n_phase   = r_phase;
        n_slot    = r_slot;
        n_bit     = r_bit;
        n_tick    = r_tick;
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_drive   = r_drive;
        n_rx_last = r_rx_last;
        n_done    = 1'b0;
        do_slot   = 1'b0;
        target    = '0;
        bit_pos   = '0;

        case (r_phase)
            PH_SYNC: begin
                n_tick = i_line_level ? tick_inc(r_tick) : '0;
                if (reached(n_tick, CMP_W'(r_sync_ticks))) begin
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (!i_line_level) begin
                    if (r_slot == 3'd0) begin
                        n_tx = {i_tx_byte3, i_tx_byte2, i_tx_byte1, i_tx_byte0};
                    end
                    if (is_rx) begin
                        n_rx = r_rx & ~(32'hFF << {r_slot[1:0], 3'b000});
                    end
                    n_tick  = TIMER_BITS'(1);
                    n_bit   = 4'd0;
                    n_phase = PH_SLOT;
                    do_slot = 1'b1;
                end
            end
            PH_SLOT: begin
                n_tick  = tick_inc(r_tick);
                do_slot = 1'b1;
            end
            PH_HALF: begin
                n_tick = tick_inc(r_tick);
                if (reached(n_tick, CMP_W'(half_bit))) begin
                    n_phase = PH_WAIT;
                end
            end
            default: begin
                n_phase = PH_SYNC;
                n_tick  = '0;
                n_slot  = 3'd0;
                n_drive = DRV_IDLE;
            end
        endcase

        // Drive or sample the next data bit, or close the slot after the last bit.
        if (do_slot) begin
            bit_pos = {r_slot[1:0], n_bit[2:0]};
            if (!n_bit[3]) begin
                target = CMP_W'(r_start_ticks)
                       + CMP_W'(n_bit[2:0]) * CMP_W'(r_bit_ticks)
                       + (is_rx ? CMP_W'(half_bit) : CMP_W'(0));
                if (reached(n_tick, target)) begin
                    if (is_rx) begin
                        if (i_line_level) begin
                            n_rx[bit_pos] = 1'b1;
                        end
                    end else begin
                        n_drive = n_tx[bit_pos] ? DRV_ONE : DRV_ZERO;
                    end
                    n_bit = n_bit + 4'd1;
                end
            end else begin
                target = CMP_W'(r_start_ticks) + (CMP_W'(r_bit_ticks) << 3);
                if (reached(n_tick, target)) begin
                    n_drive = DRV_IDLE;
                    n_tick  = '0;
                    if (r_slot == LAST_SLOT) begin
                        n_rx_last = n_rx;
                        n_done    = 1'b1;
                        n_slot    = 3'd0;
                        n_phase   = PH_SYNC;
                    end else begin
                        n_slot  = r_slot + 3'd1;
                        n_phase = (half_bit == 9'd0) ? PH_WAIT : PH_HALF;
                    end
                end
            end
        end
    end

    assign n_result.line_drive = n_drive;
    assign n_result.rx_frame   = n_rx_last;
    assign n_result.frame_done = n_done;

    // Protocol state advances on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC;
            r_slot    <= 3'd0;
            r_bit     <= 4'd0;
            r_tick    <= '0;
            r_tx      <= 32'd0;
            r_rx      <= 32'd0;
            r_drive   <= DRV_IDLE;
            r_rx_last <= 32'd0;
        end else if (in_xfer) begin
            r_phase   <= n_phase;
            r_slot    <= n_slot;
            r_bit     <= n_bit;
            r_tick    <= n_tick;
            r_tx      <= n_tx;
            r_rx      <= n_rx;
            r_drive   <= n_drive;
            r_rx_last <= n_rx_last;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_xfer) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_drive = r_out.line_drive;
    assign o_rx_byte0   = r_out.rx_frame[7:0];
    assign o_rx_byte1   = r_out.rx_frame[15:8];
    assign o_rx_byte2   = r_out.rx_frame[23:16];
    assign o_rx_byte3   = r_out.rx_frame[31:24];
    assign o_frame_done = r_out.frame_done;

endmodule

// File: tb/lanc_frame_transceiver_test.sv
// Self-checking testbench for the LANC frame transceiver: timed bus ticks in, drive and bytes out.
module lanc_frame_transceiver_test;
    import lanc_pkg::*;

    // Register index that decodes to nothing; writes to it must be ignored.
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_TICKS = 300;

    // Bus model state: timing registers plus the frame sequencer.
    typedef struct packed {
        logic [9:0]            bit_ticks;
        logic [9:0]            start_ticks;
        logic [15:0]           sync_ticks;
        t_phase                ph;
        logic [2:0]            slot;
        logic [3:0]            bit_idx;
        logic [TIMER_BITS-1:0] ticks;
        logic [31:0]           tx_frame;
        logic [31:0]           rx_frame;
        logic [31:0]           rx_last;
        t_drive                drive;
    } t_bus_state;

    // One microsecond tick as presented on the input channel.
    typedef struct packed {
        logic        line;
        logic [31:0] tx;
    } t_tick_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_line_level = 1'b0;
    logic [31:0] tx_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_line_drive;
    logic [7:0]  o_rx_byte0;
    logic [7:0]  o_rx_byte1;
    logic [7:0]  o_rx_byte2;
    logic [7:0]  o_rx_byte3;
    logic        o_frame_done;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_bus_state  bus_model;
    t_tick_item  pending_ticks[$];
    t_result     expected_bus[$];
    t_tick_item  next_tick;
    t_result     want;
    logic [31:0] got_rx;
    int          mismatches = 0;
    int          stall_cycles = 0;
    int          cycle_no = 0;

    lanc_frame_transceiver dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_line_level (i_line_level),
        .i_tx_byte0   (tx_word[7:0]),
        .i_tx_byte1   (tx_word[15:8]),
        .i_tx_byte2   (tx_word[23:16]),
        .i_tx_byte3   (tx_word[31:24]),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_line_drive (o_line_drive),
        .o_rx_byte0   (o_rx_byte0),
        .o_rx_byte1   (o_rx_byte1),
        .o_rx_byte2   (o_rx_byte2),
        .o_rx_byte3   (o_rx_byte3),
        .o_frame_done (o_frame_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 i_clk = ~i_clk;

    // The timer stops at its all-ones value.
    function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] t);
        return (t == {TIMER_BITS{1'b1}}) ? t : t + 1'b1;
    endfunction

    // A saturated timer meets every deadline.
    function automatic logic deadline_met(input logic [TIMER_BITS-1:0] t,
                                          input int unsigned target);
        return (32'(t) >= target) || (t == {TIMER_BITS{1'b1}});
    endfunction

    // Work inside a byte slot: drive or sample at most one bit, else close the slot.
    // Returns one when the frame's last slot closes.
    function automatic logic slot_step(inout t_bus_state s, input logic line);
        int unsigned half;
        int unsigned target;
        logic [4:0]  pos;
        logic        rx_slot;
        half = 32'(s.bit_ticks >> 1);
        rx_slot = s.slot[2];
        pos = {s.slot[1:0], s.bit_idx[2:0]};
        slot_step = 1'b0;
        if (s.bit_idx < 4'd8) begin
            target = 32'(s.start_ticks) + 32'(s.bit_idx) * 32'(s.bit_ticks)
                     + (rx_slot ? half : 0);
            if (deadline_met(s.ticks, target)) begin
                if (rx_slot) begin
                    if (line) s.rx_frame[pos] = 1'b1;
                end else begin
                    s.drive = s.tx_frame[pos] ? DRV_ONE : DRV_ZERO;
                end
                s.bit_idx = s.bit_idx + 4'd1;
            end
        end else if (deadline_met(s.ticks, 32'(s.start_ticks) + 8 * 32'(s.bit_ticks))) begin
            s.drive = DRV_IDLE;
            s.ticks = '0;
            if (s.slot == LAST_SLOT) begin
                s.rx_last = s.rx_frame;
                s.slot = '0;
                s.ph = PH_SYNC;
                slot_step = 1'b1;
            end else begin
                s.slot = s.slot + 3'd1;
                s.ph = (half == 0) ? PH_WAIT : PH_HALF;
            end
        end
    endfunction

    // Advance the bus model by one tick and return what the block must present.
    function automatic t_result lanc_tick(inout t_bus_state s, input logic line,
                                          input logic [31:0] tx);
        t_result r;
        logic    done;
        done = 1'b0;
        case (s.ph)
            PH_SYNC: begin
                s.ticks = line ? tick_up(s.ticks) : '0;
                if (deadline_met(s.ticks, 32'(s.sync_ticks))) s.ph = PH_WAIT;
            end
            PH_WAIT: begin
                if (!line) begin
                    // The start bit opens a slot; this tick already counts as slot time.
                    if (s.slot == 3'd0) s.tx_frame = tx;
                    if (s.slot[2]) s.rx_frame[8*s.slot[1:0] +: 8] = 8'h00;
                    s.ticks = TIMER_BITS'(1);
                    s.bit_idx = '0;
                    s.ph = PH_SLOT;
                    done = slot_step(s, line);
                end
            end
            PH_SLOT: begin
                s.ticks = tick_up(s.ticks);
                done = slot_step(s, line);
            end
            PH_HALF: begin
                s.ticks = tick_up(s.ticks);
                if (deadline_met(s.ticks, 32'(s.bit_ticks >> 1))) s.ph = PH_WAIT;
            end
            default: begin
                s.ph = PH_SYNC;
                s.ticks = '0;
                s.slot = '0;
                s.drive = DRV_IDLE;
            end
        endcase
        r.line_drive = s.drive;
        r.rx_frame = s.rx_last;
        r.frame_done = done;
        return r;
    endfunction

    // Random stalls, switched off for a long stretch in every window of cycles.
    function automatic logic pause_now();
        return ((cycle_no % 1500) < 1100) && ($urandom_range(99) < 27);
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        $display("ERROR at %0t: %s is %0h, expected %0h", $time, field, got, exp_val);
        mismatches++;
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BIT_TICKS:   bus_model.bit_ticks = value[9:0];
            REG_START_TICKS: bus_model.start_ticks = value[9:0];
            REG_SYNC_TICKS:  bus_model.sync_ticks = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_timing(input logic [9:0] bits, input logic [9:0] start,
                               input logic [15:0] sync);
        write_register(REG_BIT_TICKS, 32'(bits));
        write_register(REG_START_TICKS, 32'(start));
        write_register(REG_SYNC_TICKS, 32'(sync));
    endtask

    // Plan ticks against a private copy of the bus model so the line level fits
    // the phase: long highs for sync, start bits in the wait, random data in slots.
    // Then hold the sender back until every result is in.
    task automatic queue_ticks(input int frames, input int max_items, input int noise,
                               output int made);
        t_bus_state plan;
        t_tick_item tk;
        t_result    r;
        int         done_count;
        plan = bus_model;
        done_count = 0;
        made = 0;
        while (done_count < frames && made < max_items) begin
            case (plan.ph)
                PH_SYNC: tk.line = ($urandom_range(99) >= noise);
                PH_WAIT: tk.line = ($urandom_range(99) >= 40);
                default: tk.line = 1'($urandom_range(1));
            endcase
            case ($urandom_range(7))
                0:       tk.tx = '0;
                1:       tk.tx = '1;
                default: tk.tx = $urandom;
            endcase
            r = lanc_tick(plan, tk.line, tk.tx);
            if (r.frame_done) done_count++;
            pending_ticks.push_back(tk);
            made++;
        end
        while (pending_ticks.size() != 0 || i_in_valid || expected_bus.size() != 0)
            @(posedge i_clk);
    endtask

    // Stimulus: reset defaults, corner settings, then random small timings.
    initial begin
        int made;
        int random_total;
        bus_model = '0;
        bus_model.bit_ticks = BIT_TICKS_RST;
        bus_model.start_ticks = START_TICKS_RST;
        bus_model.sync_ticks = SYNC_TICKS_RST;
        bus_model.ph = PH_SYNC;
        bus_model.drive = DRV_IDLE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing: the sync counter climbs and is cleared by low ticks.
        queue_ticks(1, 100, 2, made);
        // Zero bit length and zero sync gap: bits one per tick, no half-bit wait.
        load_timing(10'd0, 10'd1, 16'd0);
        queue_ticks(2, 300, 5, made);
        // Unmapped register, and a write whose upper data bits must be dropped.
        write_register(REG_SPARE, 32'hFFFF_FFFF);
        write_register(REG_BIT_TICKS, 32'hABCD_0401);
        queue_ticks(2, 300, 5, made);
        // Longest start bit with the shortest legal bit: cover the first command slot.
        load_timing(10'd2, 10'd1023, 16'd1);
        queue_ticks(1, 1100, 5, made);

        random_total = 0;
        while (random_total < RANDOM_TICKS) begin
            if ($urandom_range(9) == 0)
                load_timing(10'($urandom_range(1)), 10'($urandom_range(4)),
                            16'($urandom_range(12)));
            else
                load_timing(10'($urandom_range(5, 2)), 10'($urandom_range(4)),
                            16'($urandom_range(12)));
            queue_ticks($urandom_range(3, 1), 300, 4, made);
            random_total += made;
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_bus.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Input side: record the expectation for each transfer, then offer the next tick.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_bus.push_back(lanc_tick(bus_model, i_line_level, tx_word));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_ticks.size() != 0 && !pause_now()) begin
                    next_tick = pending_ticks.pop_front();
                    i_in_valid <= 1'b1;
                    i_line_level <= next_tick.line;
                    tx_word <= next_tick.tx;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: compare each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_bus.size() == 0) begin
                    flag_mismatch("unexpected result, line_drive", 32'(o_line_drive), 0);
                end else begin
                    want = expected_bus.pop_front();
                    got_rx = {o_rx_byte3, o_rx_byte2, o_rx_byte1, o_rx_byte0};
                    if (o_line_drive !== want.line_drive)
                        flag_mismatch("line_drive", 32'(o_line_drive), 32'(want.line_drive));
                    for (int k = 0; k < 4; k++) begin
                        if (got_rx[8*k +: 8] !== want.rx_frame[8*k +: 8])
                            flag_mismatch($sformatf("rx_byte%0d", k),
                                          32'(got_rx[8*k +: 8]),
                                          32'(want.rx_frame[8*k +: 8]));
                    end
                    if (o_frame_done !== want.frame_done)
                        flag_mismatch("frame_done", 32'(o_frame_done), 32'(want.frame_done));
                end
            end
            i_out_ready <= !pause_now();
        end
    end

    // Watchdog: give up after too many cycles without any transfer.
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

// File: sim.f
rtl/lanc_pkg.sv
rtl/lanc_frame_transceiver.sv
tb/lanc_frame_transceiver_test.sv
